/* hw/rtl/mcre_pkg.sv */
// Package of the mailbox command retry engine: types, codes and reset values.
`timescale 1ns / 1ps

package mcre_pkg;

   // Request kinds carried by a transaction on the input channel
   localparam logic [1:0] REQ_ISSUE   = 2'd0;
   localparam logic [1:0] REQ_OBSERVE = 2'd1;
   localparam logic [1:0] REQ_TICK    = 2'd2;

   // Result kinds and completion status
   localparam logic KIND_WRITE = 1'b0;
   localparam logic KIND_DONE  = 1'b1;
   localparam logic STATUS_OK      = 1'b0;
   localparam logic STATUS_TIMEOUT = 1'b1;

   // The clear command written before a command whose echo is already present
   localparam logic [7:0]  CLEAR_CODE  = 8'h00;
   localparam logic [15:0] CLEAR_PARAM = 16'h0000;

   // Configuration register indexes
   localparam int unsigned CSR_INDEX_WIDTH = 2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_TIMEOUT_TICKS = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_COMMAND_TRIES = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_CLEAR_TRIES   = 2'd2;
   localparam int unsigned CSR_DATA_WIDTH = 16;

   // Configuration reset values
   localparam logic [15:0] TIMEOUT_TICKS_RESET = 16'd250;
   localparam logic [3:0]  COMMAND_TRIES_RESET = 4'd3;
   localparam logic [3:0]  CLEAR_TRIES_RESET   = 4'd2;

   typedef enum logic [1:0] {
      PH_IDLE  = 2'd0,
      PH_CLEAR = 2'd1,
      PH_CMD   = 2'd2
   } phase_type;

   typedef struct packed {
      logic [15:0] timeout_ticks;
      logic [3:0]  command_tries;
      logic [3:0]  clear_tries;
   } cfg_type;

   typedef struct packed {
      logic [1:0]  req_type;
      logic [7:0]  cmd_code;
      logic [15:0] param_word;
      logic [7:0]  echo_code;
      logic [15:0] feedback_word;
   } item_type;

   typedef struct packed {
      logic        out_kind;
      logic [7:0]  out_code;
      logic [15:0] out_param;
      logic        done_status;
      logic [15:0] done_data;
   } result_type;

endpackage

/* hw/rtl/mcre_channels.sv */
// Valid/ready channel interfaces for the request and response sides of the engine.
`timescale 1ns / 1ps

interface mcre_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  req_type;
   logic [7:0]  cmd_code;
   logic [15:0] param_word;
   logic [7:0]  echo_code;
   logic [15:0] feedback_word;

   modport source (
      output valid, req_type, cmd_code, param_word, echo_code, feedback_word,
      input  ready
   );
   modport sink (
      input  valid, req_type, cmd_code, param_word, echo_code, feedback_word,
      output ready
   );
endinterface

interface mcre_rsp_if;
   logic        valid;
   logic        ready;
   logic        out_kind;
   logic [7:0]  out_code;
   logic [15:0] out_param;
   logic        done_status;
   logic [15:0] done_data;

   modport source (
      output valid, out_kind, out_code, out_param, done_status, done_data,
      input  ready
   );
   modport sink (
      input  valid, out_kind, out_code, out_param, done_status, done_data,
      output ready
   );
endinterface

/* hw/rtl/mcre_core.sv */
// Retry state machine of the engine: phase, pending command, timers and result.
`timescale 1ns / 1ps

module mcre_core
   import mcre_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  cfg_type    cfg,
   input  logic       step,
   input  item_type   item,
   output logic       res_valid,
   output result_type res
);

   phase_type   phase_ff, phase_in;
   logic [7:0]  pending_code_ff, pending_code_in;
   logic [15:0] pending_param_ff, pending_param_in;
   logic [15:0] wait_count_ff, wait_count_in;
   logic [3:0]  try_count_ff, try_count_in;

   logic [15:0] wait_next;
   logic [15:0] limit;
   logic [3:0]  tries;
   logic        expired;
   logic        last_try;
   logic        busy;

   assign busy      = (phase_ff == PH_CLEAR) || (phase_ff == PH_CMD);
   assign wait_next = wait_count_ff + 16'd1;
   assign limit     = (cfg.timeout_ticks == 16'd0) ? 16'd1 : cfg.timeout_ticks;
   assign expired   = (wait_next >= limit);
   assign tries     = (phase_ff == PH_CLEAR) ? cfg.clear_tries : cfg.command_tries;
   assign last_try  = !(try_count_ff < tries);

   // Next phase
   always_comb begin
      phase_in = phase_ff;
      if (step) begin
         case (item.req_type)
            REQ_ISSUE: begin
               if (phase_ff == PH_IDLE) begin
                  phase_in = (item.echo_code == item.cmd_code) ? PH_CLEAR : PH_CMD;
               end
            end
            REQ_OBSERVE: begin
               if (phase_ff == PH_CLEAR && item.echo_code == CLEAR_CODE) begin
                  phase_in = PH_CMD;
               end else if (phase_ff == PH_CMD && item.echo_code == pending_code_ff) begin
                  phase_in = PH_IDLE;
               end
            end
            REQ_TICK: begin
               if (busy && expired && last_try) begin
                  phase_in = PH_IDLE;
               end
            end
            default: phase_in = phase_ff;
         endcase
      end
   end

   // Counters, pending command and the result of the transaction
   always_comb begin
      pending_code_in  = pending_code_ff;
      pending_param_in = pending_param_ff;
      wait_count_in    = wait_count_ff;
      try_count_in     = try_count_ff;
      res_valid        = 1'b0;
      res              = '0;
      if (step) begin
         case (item.req_type)
            REQ_ISSUE: begin
               if (phase_ff == PH_IDLE) begin
                  pending_code_in  = item.cmd_code;
                  pending_param_in = item.param_word;
                  wait_count_in    = '0;
                  try_count_in     = 4'd1;
                  res_valid        = 1'b1;
                  res.out_kind     = KIND_WRITE;
                  if (item.echo_code == item.cmd_code) begin
                     res.out_code  = CLEAR_CODE;
                     res.out_param = CLEAR_PARAM;
                  end else begin
                     res.out_code  = item.cmd_code;
                     res.out_param = item.param_word;
                  end
               end
            end
            REQ_OBSERVE: begin
               if (phase_ff == PH_CLEAR && item.echo_code == CLEAR_CODE) begin
                  wait_count_in = '0;
                  try_count_in  = 4'd1;
                  res_valid     = 1'b1;
                  res.out_kind  = KIND_WRITE;
                  res.out_code  = pending_code_ff;
                  res.out_param = pending_param_ff;
               end else if (phase_ff == PH_CMD && item.echo_code == pending_code_ff) begin
                  wait_count_in   = '0;
                  try_count_in    = '0;
                  res_valid       = 1'b1;
                  res.out_kind    = KIND_DONE;
                  res.done_status = STATUS_OK;
                  res.done_data   = item.feedback_word;
               end
            end
            REQ_TICK: begin
               if (busy) begin
                  wait_count_in = wait_next;
                  if (expired) begin
                     wait_count_in = '0;
                     res_valid     = 1'b1;
                     if (!last_try) begin
                        try_count_in = try_count_ff + 4'd1;
                        res.out_kind = KIND_WRITE;
                        if (phase_ff == PH_CLEAR) begin
                           res.out_code  = CLEAR_CODE;
                           res.out_param = CLEAR_PARAM;
                        end else begin
                           res.out_code  = pending_code_ff;
                           res.out_param = pending_param_ff;
                        end
                     end else begin
                        try_count_in    = '0;
                        res.out_kind    = KIND_DONE;
                        res.done_status = STATUS_TIMEOUT;
                     end
                  end
               end
            end
            default: res_valid = 1'b0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff         <= PH_IDLE;
         pending_code_ff  <= '0;
         pending_param_ff <= '0;
         wait_count_ff    <= '0;
         try_count_ff     <= '0;
      end else begin
         phase_ff         <= phase_in;
         pending_code_ff  <= pending_code_in;
         pending_param_ff <= pending_param_in;
         wait_count_ff    <= wait_count_in;
         try_count_ff     <= try_count_in;
      end
   end

   // An idle engine holds no attempt and no running timer.
   a_idle_clear: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_IDLE |-> (try_count_ff == 4'd0 && wait_count_ff == 16'd0))
      else $error("idle engine with live attempt state");

   // While a phase runs, at least one attempt has been made.
   a_busy_tries: assert property (@(posedge clock) disable iff (reset)
      phase_ff != PH_IDLE |-> try_count_ff != 4'd0)
      else $error("busy engine with no attempt counted");

   // A completion returns the engine to idle.
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      (step && res_valid && res.out_kind == KIND_DONE) |=> phase_ff == PH_IDLE)
      else $error("completion did not return engine to idle");

   // A new command is only written from idle.
   a_issue_idle: assert property (@(posedge clock) disable iff (reset)
      (step && res_valid && item.req_type == REQ_ISSUE) |-> phase_ff == PH_IDLE)
      else $error("issue produced a write while busy");

endmodule

/* hw/rtl/mailbox_command_retry_engine.sv */
// Top level of the mailbox command retry engine: channels, configuration and stages.
`timescale 1ns / 1ps

// The engine takes one transaction per clock on the request channel unless stalled:
// issue a command, report a mailbox observation, or mark one microsecond tick. Each
// transaction yields at most one response (a mailbox write of code and parameter, or
// a finished request with its status and feedback word), which is produced once the
// transaction has passed the input register and the single step of the retry state
// machine into the response register. Sustained throughput is one transaction per
// cycle while the response side keeps up; the rate is set by that single step, which
// updates the phase, the attempt counter and the tick counter together. A waiting
// response stalls the request side only once the input register is full as well: the
// input register accepts whenever it is empty or its transaction moves on in the same
// cycle, and it moves on when the response register is empty or is being emptied in
// that cycle. Configuration registers are written through the csr port and should
// only be changed while no request is in progress.

module mailbox_command_retry_engine
   import mcre_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   mcre_req_if.sink                   req_chan,
   mcre_rsp_if.source                 rsp_chan,
   input  logic                       csr_write_enable,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_data
);

   cfg_type    cfg_ff;
   logic       in_valid_ff, in_valid_in;
   item_type   in_item_ff;
   logic       out_valid_ff, out_valid_in;
   result_type out_result_ff;

   logic       consume;
   logic       res_valid;
   result_type res;
   item_type   req_item;

   // The staged transaction moves into the state machine whenever the response
   // register has room for what it may produce.
   assign consume        = in_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !in_valid_ff || consume;

   assign req_item.req_type      = req_chan.req_type;
   assign req_item.cmd_code      = req_chan.cmd_code;
   assign req_item.param_word    = req_chan.param_word;
   assign req_item.echo_code     = req_chan.echo_code;
   assign req_item.feedback_word = req_chan.feedback_word;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_chan.valid && req_chan.ready) begin
         in_valid_in = 1'b1;
      end else if (consume) begin
         in_valid_in = 1'b0;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (consume) begin
         out_valid_in = res_valid;
      end else if (rsp_chan.ready) begin
         out_valid_in = 1'b0;
      end
   end

   // Configuration registers; writes to an unused index are dropped.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.timeout_ticks <= TIMEOUT_TICKS_RESET;
         cfg_ff.command_tries <= COMMAND_TRIES_RESET;
         cfg_ff.clear_tries   <= CLEAR_TRIES_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_TIMEOUT_TICKS: cfg_ff.timeout_ticks <= csr_data;
            CSR_COMMAND_TRIES: cfg_ff.command_tries <= csr_data[3:0];
            CSR_CLEAR_TRIES:   cfg_ff.clear_tries   <= csr_data[3:0];
            default:           cfg_ff <= cfg_ff;
         endcase
      end
   end

   // Input register and response register valid flags.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payloads carry no reset; they are qualified by the valid flags above.
   always_ff @(posedge clock) begin
      if (req_chan.valid && req_chan.ready) begin
         in_item_ff <= req_item;
      end
      if (consume && res_valid) begin
         out_result_ff <= res;
      end
   end

   mcre_core u_core (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .step      (consume),
      .item      (in_item_ff),
      .res_valid (res_valid),
      .res       (res)
   );

   assign rsp_chan.valid       = out_valid_ff;
   assign rsp_chan.out_kind    = out_result_ff.out_kind;
   assign rsp_chan.out_code    = out_result_ff.out_code;
   assign rsp_chan.out_param   = out_result_ff.out_param;
   assign rsp_chan.done_status = out_result_ff.done_status;
   assign rsp_chan.done_data   = out_result_ff.done_data;

endmodule

/* tb/sv/tb_mailbox_command_retry_engine.sv */
// Self-checking testbench of the mailbox command retry engine with its own prediction.
`timescale 1ns / 1ps

// The testbench drives request transactions into the engine and predicts the
// response of each accepted transaction. A predictor in this module keeps its own
// copy of the retry state and the configuration. Each accepted transaction is run
// through the predictor at the clock edge where it is accepted. Any response it
// causes goes to the back of a queue. A separate process takes each response from
// the engine, compares it field by field with the oldest entry of that queue and
// reports each difference while no more than MAX_REPORTS errors have been counted.
//
// Inputs change on the falling edge and outputs are sampled on the rising edge.
// Both sides therefore see settled values and no check depends on event order.
// The configuration is only written while no request is in progress and every
// predicted response has been taken.

module tb_mailbox_command_retry_engine;
   import mcre_pkg::*;

   // Codes that the package does not name: the spare register slot and the
   // request kind that the engine must ignore.
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SPARE_INDEX = 2'd3;
   localparam logic [1:0]                 REQ_RESERVED    = 2'd3;

   localparam int MAX_GAP       = 11;   // longest idle stretch drawn by either side
   localparam int SETTLE_CYCLES = 4;    // waited after the last predicted response is taken
   localparam int MAX_REPORTS   = 40;   // keeps the log readable if everything goes wrong
   localparam int RANDOM_ITEMS  = 600;
   localparam int SEGMENTS      = 5;

   logic                       clock = 1'b0;
   logic                       reset;
   logic                       csr_write_enable;
   logic [CSR_INDEX_WIDTH-1:0] csr_index;
   logic [CSR_DATA_WIDTH-1:0]  csr_data;

   mcre_req_if req_chan ();
   mcre_rsp_if rsp_chan ();

   mailbox_command_retry_engine uut (
      .clock            (clock),
      .reset            (reset),
      .req_chan         (req_chan),
      .rsp_chan         (rsp_chan),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   // The period is 4 ns, high for 2 ns and low for 2 ns.
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // The predictor's copy of the engine: configuration, retry state and the
   // responses that are still to come, oldest first.
   cfg_type      eng_cfg;
   phase_type    eng_phase;
   logic [7:0]   pend_code;
   logic [15:0]  pend_param;
   logic [15:0]  wait_cnt;
   logic [3:0]   try_cnt;
   result_type   expected_results[$];

   int error_count   = 0;
   int results_seen  = 0;
   int req_max_gap   = MAX_GAP;
   int rsp_max_stall = MAX_GAP;

   // A finished request leaves the engine idle with its counters cleared.
   function automatic result_type close_request(input logic status, input logic [15:0] data);
      result_type res;
      res             = '0;
      res.out_kind    = KIND_DONE;
      res.done_status = status;
      res.done_data   = data;
      eng_phase       = PH_IDLE;
      wait_cnt        = '0;
      try_cnt         = '0;
      return res;
   endfunction

   // Advances the predicted state by one accepted transaction. The return value
   // tells whether the transaction causes a response, and res holds that response.
   function automatic bit engine_step(input item_type it, output result_type res);
      logic [15:0] limit;
      logic [3:0]  tries;
      res         = '0;
      engine_step = 1'b0;
      case (it.req_type)
         REQ_ISSUE: begin
            // A new command while a request is in progress is dropped.
            if (eng_phase == PH_IDLE) begin
               pend_code    = it.cmd_code;
               pend_param   = it.param_word;
               wait_cnt     = '0;
               try_cnt      = 4'd1;
               res.out_kind = KIND_WRITE;
               // An echo that already shows the new code would confirm it at once,
               // so the mailbox is cleared first.
               if (it.echo_code == it.cmd_code) begin
                  eng_phase     = PH_CLEAR;
                  res.out_code  = CLEAR_CODE;
                  res.out_param = CLEAR_PARAM;
               end else begin
                  eng_phase     = PH_CMD;
                  res.out_code  = pend_code;
                  res.out_param = pend_param;
               end
               engine_step = 1'b1;
            end
         end
         REQ_OBSERVE: begin
            if (eng_phase == PH_CLEAR && it.echo_code == CLEAR_CODE) begin
               eng_phase     = PH_CMD;
               wait_cnt      = '0;
               try_cnt       = 4'd1;
               res.out_kind  = KIND_WRITE;
               res.out_code  = pend_code;
               res.out_param = pend_param;
               engine_step   = 1'b1;
            end else if (eng_phase == PH_CMD && it.echo_code == pend_code) begin
               res         = close_request(STATUS_OK, it.feedback_word);
               engine_step = 1'b1;
            end
         end
         REQ_TICK: begin
            if (eng_phase != PH_IDLE) begin
               wait_cnt = wait_cnt + 16'd1;
               // A zero timeout behaves as one tick.
               limit = (eng_cfg.timeout_ticks == '0) ? 16'd1 : eng_cfg.timeout_ticks;
               if (wait_cnt >= limit) begin
                  tries = (eng_phase == PH_CLEAR) ? eng_cfg.clear_tries
                                                  : eng_cfg.command_tries;
                  engine_step = 1'b1;
                  // With a try limit of zero the first expiry already ends the phase.
                  if (try_cnt < tries) begin
                     try_cnt      = try_cnt + 4'd1;
                     wait_cnt     = '0;
                     res.out_kind = KIND_WRITE;
                     if (eng_phase == PH_CLEAR) begin
                        res.out_code  = CLEAR_CODE;
                        res.out_param = CLEAR_PARAM;
                     end else begin
                        res.out_code  = pend_code;
                        res.out_param = pend_param;
                     end
                  end else begin
                     res = close_request(STATUS_TIMEOUT, 16'h0000);
                  end
               end
            end
         end
         default: ;   // the reserved request kind changes nothing
      endcase
   endfunction

   function automatic item_type make_item(input logic [1:0] kind, input logic [7:0] code,
                                          input logic [15:0] param, input logic [7:0] echo,
                                          input logic [15:0] fb);
      item_type it;
      it.req_type      = kind;
      it.cmd_code      = code;
      it.param_word    = param;
      it.echo_code     = echo;
      it.feedback_word = fb;
      return it;
   endfunction

   // Fields that the request kind does not use are random as well, so that the
   // engine is seen to ignore them.
   function automatic item_type random_item(input logic [1:0] kind);
      logic [31:0] r0;
      logic [31:0] r1;
      r0 = $urandom;
      r1 = $urandom;
      return make_item(kind, r0[7:0], r0[31:16], r0[15:8], r1[15:0]);
   endfunction

   // Sends one transaction after a random idle stretch and runs it through the
   // predictor at the edge where it is accepted. Valid is left high, so the next
   // call can follow in the very next cycle.
   task automatic send_item(input item_type it);
      int         gap;
      result_type res;
      gap = $urandom_range(req_max_gap, 0);
      @(negedge clock);
      if (gap != 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_chan.valid         <= 1'b1;
      req_chan.req_type      <= it.req_type;
      req_chan.cmd_code      <= it.cmd_code;
      req_chan.param_word    <= it.param_word;
      req_chan.echo_code     <= it.echo_code;
      req_chan.feedback_word <= it.feedback_word;
      do @(posedge clock); while (req_chan.ready !== 1'b1);
      if (engine_step(it, res)) begin
         expected_results.push_back(res);
      end
   endtask

   // Stops the request side and waits until every predicted response has been
   // taken, then lets the pipeline empty.
   task automatic wait_idle();
      @(negedge clock);
      req_chan.valid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Feeds ticks until the request in progress has run out of tries.
   task automatic run_out_ticks();
      while (eng_phase != PH_IDLE) begin
         send_item(random_item(REQ_TICK));
      end
   endtask

   // Writes all three registers and the spare slot, which must be ignored. The
   // try counts are written with random upper data bits, which the engine drops.
   task automatic apply_config(input logic [15:0] ticks, input logic [3:0] cmd_tries,
                               input logic [3:0] clr_tries);
      logic [31:0] r;
      r = $urandom;
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= CSR_TIMEOUT_TICKS;
      csr_data         <= ticks;
      @(negedge clock);
      csr_index        <= CSR_COMMAND_TRIES;
      csr_data         <= {r[11:0], cmd_tries};
      @(negedge clock);
      csr_index        <= CSR_CLEAR_TRIES;
      csr_data         <= {r[27:16], clr_tries};
      @(negedge clock);
      csr_index        <= CSR_SPARE_INDEX;
      csr_data         <= r[31:16];
      @(negedge clock);
      csr_write_enable <= 1'b0;
      eng_cfg.timeout_ticks = ticks;
      eng_cfg.command_tries = cmd_tries;
      eng_cfg.clear_tries   = clr_tries;
   endtask

   // Writes the timeout alone, so that both try counts keep their reset values.
   task automatic write_timeout(input logic [15:0] ticks);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= CSR_TIMEOUT_TICKS;
      csr_data         <= ticks;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      eng_cfg.timeout_ticks = ticks;
   endtask

   // Directed sequences with the reset settings: ignored transactions, the plain
   // command path, the clear path and the field extremes.
   task automatic test_directed_sequences();
      send_item(make_item(REQ_TICK, 8'h00, 16'h0000, 8'h00, 16'h0000));
      send_item(make_item(REQ_OBSERVE, 8'h00, 16'h0000, 8'h00, 16'hffff));
      send_item(make_item(REQ_RESERVED, 8'hff, 16'hffff, 8'hff, 16'hffff));
      send_item(make_item(REQ_ISSUE, 8'hff, 16'hffff, 8'h00, 16'h0000));
      // A second command while the first waits for its echo is dropped.
      send_item(make_item(REQ_ISSUE, 8'h12, 16'h3456, 8'h00, 16'h0000));
      send_item(make_item(REQ_OBSERVE, 8'h00, 16'h0000, 8'h00, 16'h1111));
      send_item(make_item(REQ_TICK, 8'h00, 16'h0000, 8'hff, 16'h0000));
      send_item(make_item(REQ_OBSERVE, 8'h00, 16'h0000, 8'hff, 16'hffff));
      // Code zero with an echo of zero: clear first, then the same echo confirms both.
      send_item(make_item(REQ_ISSUE, 8'h00, 16'h0000, 8'h00, 16'h0000));
      send_item(make_item(REQ_OBSERVE, 8'h00, 16'h0000, 8'h5a, 16'h0000));
      send_item(make_item(REQ_OBSERVE, 8'h00, 16'h0000, 8'h00, 16'h1234));
      send_item(make_item(REQ_OBSERVE, 8'h00, 16'h0000, 8'h00, 16'h0000));
      // The echo sampled with the command only decides on the clear.
      send_item(make_item(REQ_ISSUE, 8'h80, 16'h8000, 8'h80, 16'h0000));
      send_item(make_item(REQ_OBSERVE, 8'h00, 16'h0000, 8'h80, 16'h0000));
      send_item(make_item(REQ_OBSERVE, 8'h00, 16'h0000, 8'h00, 16'h0000));
      send_item(make_item(REQ_RESERVED, 8'h80, 16'h8000, 8'h80, 16'h0000));
      send_item(make_item(REQ_OBSERVE, 8'h00, 16'h0000, 8'h80, 16'ha5c3));
   endtask

   // The reset timeout expires the first attempt on its last tick and the retry is
   // then confirmed. With a short timeout the reset try counts run out, and after
   // that the largest try counts.
   task automatic test_retry_exhaustion();
      send_item(make_item(REQ_ISSUE, 8'h21, 16'h4321, 8'h00, 16'h0000));
      for (int k = 0; k < int'(TIMEOUT_TICKS_RESET); k++) begin
         send_item(random_item(REQ_TICK));
      end
      send_item(make_item(REQ_OBSERVE, 8'h00, 16'h0000, 8'h21, 16'h7777));
      wait_idle();
      write_timeout(16'd3);
      send_item(make_item(REQ_ISSUE, 8'h24, 16'h4224, 8'h00, 16'h0000));
      run_out_ticks();
      send_item(make_item(REQ_ISSUE, 8'h42, 16'h2442, 8'h42, 16'h0000));
      run_out_ticks();
      wait_idle();
      apply_config(16'd2, 4'd15, 4'd15);
      send_item(make_item(REQ_ISSUE, 8'h99, 16'h0f0f, 8'h99, 16'h0000));
      run_out_ticks();
      send_item(make_item(REQ_ISSUE, 8'h66, 16'hf0f0, 8'h01, 16'h0000));
      run_out_ticks();
      // A clear that is only confirmed after some retries.
      send_item(make_item(REQ_ISSUE, 8'h5c, 16'h1357, 8'h5c, 16'h0000));
      for (int k = 0; k < 5; k++) begin
         send_item(random_item(REQ_TICK));
      end
      send_item(make_item(REQ_OBSERVE, 8'h00, 16'h0000, 8'h00, 16'h0000));
      run_out_ticks();
      wait_idle();
   endtask

   // A zero timeout acts as one tick and zero tries act as one.
   task automatic test_zero_settings();
      apply_config(16'd0, 4'd0, 4'd0);
      send_item(make_item(REQ_ISSUE, 8'h33, 16'h3333, 8'h33, 16'h0000));
      send_item(make_item(REQ_TICK, 8'h00, 16'h0000, 8'h00, 16'h0000));
      send_item(make_item(REQ_ISSUE, 8'h44, 16'h4444, 8'h00, 16'h0000));
      send_item(make_item(REQ_TICK, 8'h00, 16'h0000, 8'h44, 16'h0000));
      send_item(make_item(REQ_ISSUE, 8'h55, 16'h5555, 8'haa, 16'h0000));
      send_item(make_item(REQ_OBSERVE, 8'h00, 16'h0000, 8'h55, 16'h0f0f));
      wait_idle();
   endtask

   // The largest timeout: a few ticks in each phase expire nothing, and both the
   // clear and the command are confirmed. The sender runs without gaps here.
   task automatic test_longest_timeout();
      apply_config(16'hffff, 4'd1, 4'd1);
      req_max_gap = 0;
      send_item(make_item(REQ_ISSUE, 8'h3c, 16'hc3c3, 8'h3c, 16'h0000));
      for (int k = 0; k < 3; k++) begin
         send_item(random_item(REQ_TICK));
      end
      send_item(make_item(REQ_OBSERVE, 8'h00, 16'h0000, 8'h00, 16'h0000));
      for (int k = 0; k < 3; k++) begin
         send_item(random_item(REQ_TICK));
      end
      send_item(make_item(REQ_OBSERVE, 8'h00, 16'h0000, 8'h3c, 16'h5a5a));
      send_item(make_item(REQ_ISSUE, 8'h7e, 16'h0101, 8'h00, 16'h0000));
      for (int k = 0; k < 3; k++) begin
         send_item(random_item(REQ_TICK));
      end
      send_item(make_item(REQ_OBSERVE, 8'h00, 16'h0000, 8'h7e, 16'hbeef));
      req_max_gap = MAX_GAP;
      wait_idle();
   endtask

   // Random traffic in segments, each with its own settings and one of four idling patterns.
   // Most transactions follow a request through its phases. The rest are
   // unmatched echoes, commands while busy, stray observations and ticks, and the
   // reserved kind. Only issues from idle and observations and ticks while busy count.
   task automatic test_random_traffic();
      int          counted;
      int          pick;
      item_type    it;
      logic [31:0] r;
      logic [15:0] ticks;
      logic [3:0]  cmd_tries;
      logic [3:0]  clr_tries;
      for (int seg = 0; seg < SEGMENTS; seg++) begin
         run_out_ticks();
         wait_idle();
         r = $urandom_range(8, 2);
         case ($urandom_range(3, 0))
            0:       ticks = 16'd0;
            1:       ticks = 16'd1;
            default: ticks = r[15:0];
         endcase
         r = $urandom_range(14, 1);
         case ($urandom_range(3, 0))
            0:       cmd_tries = 4'd0;
            1:       cmd_tries = 4'd15;
            default: cmd_tries = r[3:0];
         endcase
         r = $urandom_range(14, 1);
         case ($urandom_range(3, 0))
            0:       clr_tries = 4'd0;
            1:       clr_tries = 4'd15;
            default: clr_tries = r[3:0];
         endcase
         apply_config(ticks, cmd_tries, clr_tries);
         case (seg % 4)
            0: begin req_max_gap = MAX_GAP; rsp_max_stall = MAX_GAP; end
            1: begin req_max_gap = 0;       rsp_max_stall = 0;       end
            2: begin req_max_gap = 0;       rsp_max_stall = MAX_GAP; end
            default: begin req_max_gap = MAX_GAP; rsp_max_stall = 0; end
         endcase
         counted = 0;
         while (counted < RANDOM_ITEMS / SEGMENTS) begin
            it   = random_item(REQ_TICK);
            pick = $urandom_range(99, 0);
            case ($urandom_range(7, 0))
               0:       it.cmd_code = 8'h00;
               1:       it.cmd_code = 8'hff;
               default: ;
            endcase
            if (eng_phase == PH_IDLE) begin
               if (pick < 88) begin
                  it.req_type = REQ_ISSUE;
                  if (pick < 30) begin
                     it.echo_code = it.cmd_code;
                  end
                  counted++;
               end else if (pick < 93) begin
                  it.req_type = REQ_OBSERVE;
               end else if (pick < 97) begin
                  it.req_type = REQ_TICK;
               end else begin
                  it.req_type = REQ_RESERVED;
               end
            end else begin
               if (pick < 30) begin
                  it.req_type  = REQ_OBSERVE;
                  it.echo_code = (eng_phase == PH_CLEAR) ? CLEAR_CODE : pend_code;
                  counted++;
               end else if (pick < 42) begin
                  it.req_type = REQ_OBSERVE;
                  counted++;
               end else if (pick < 92) begin
                  it.req_type = REQ_TICK;
                  counted++;
               end else if (pick < 96) begin
                  it.req_type = REQ_ISSUE;
               end else begin
                  it.req_type = REQ_RESERVED;
               end
            end
            send_item(it);
         end
      end
      req_max_gap   = MAX_GAP;
      rsp_max_stall = MAX_GAP;
   endtask

   // Response side: after each response taken, ready stays low for a random
   // number of cycles and then stays high until the next response is taken.
   int rsp_stall = 0;
   int rsp_noted = 0;

   always @(negedge clock) begin
      if (rsp_noted != results_seen) begin
         rsp_noted = results_seen;
         rsp_stall = $urandom_range(rsp_max_stall, 0);
      end
      if (rsp_stall != 0) begin
         rsp_chan.ready <= 1'b0;
         rsp_stall = rsp_stall - 1;
      end else begin
         rsp_chan.ready <= 1'b1;
      end
   end

   task automatic check_field(input string name, input logic [15:0] want,
                              input logic [15:0] got);
      if (got !== want) begin
         error_count++;
         if (error_count <= MAX_REPORTS) begin
            $display("%0t ns: %s mismatch, expected %h, actual %h", $time, name, want, got);
         end
      end
   endtask

   // Each response taken is compared with the oldest prediction.
   always @(posedge clock) begin : check_responses
      result_type want;
      if (!reset && rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1) begin
         results_seen++;
         if (expected_results.size() == 0) begin
            error_count++;
            if (error_count <= MAX_REPORTS) begin
               $display("%0t ns: unexpected response, expected none, actual %b %h %h %b %h",
                        $time, rsp_chan.out_kind, rsp_chan.out_code, rsp_chan.out_param,
                        rsp_chan.done_status, rsp_chan.done_data);
            end
         end else begin
            want = expected_results.pop_front();
            check_field("out_kind", {15'd0, want.out_kind}, {15'd0, rsp_chan.out_kind});
            check_field("out_code", {8'd0, want.out_code}, {8'd0, rsp_chan.out_code});
            check_field("out_param", want.out_param, rsp_chan.out_param);
            check_field("done_status", {15'd0, want.done_status},
                        {15'd0, rsp_chan.done_status});
            check_field("done_data", want.done_data, rsp_chan.done_data);
         end
      end
   end

   initial begin
      reset                  = 1'b1;
      csr_write_enable       = 1'b0;
      csr_index              = CSR_TIMEOUT_TICKS;
      csr_data               = '0;
      req_chan.valid         = 1'b0;
      req_chan.req_type      = REQ_ISSUE;
      req_chan.cmd_code      = '0;
      req_chan.param_word    = '0;
      req_chan.echo_code     = '0;
      req_chan.feedback_word = '0;
      rsp_chan.ready         = 1'b0;

      eng_cfg.timeout_ticks = TIMEOUT_TICKS_RESET;
      eng_cfg.command_tries = COMMAND_TRIES_RESET;
      eng_cfg.clear_tries   = CLEAR_TRIES_RESET;
      eng_phase  = PH_IDLE;
      pend_code  = '0;
      pend_param = '0;
      wait_cnt   = '0;
      try_cnt    = '0;

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed_sequences();
      test_retry_exhaustion();
      test_zero_settings();
      test_longest_timeout();
      test_random_traffic();

      // Let the last request finish and every response drain before judging.
      run_out_ticks();
      wait_idle();
      if (expected_results.size() != 0) begin
         error_count++;
      end
      if (error_count == 0) begin
         $display("[mailbox_command_retry_engine] OK");
      end else begin
         $display("[mailbox_command_retry_engine] ERROR");
      end
      $finish;
   end

   // A correct run needs well under half a millisecond, so this only fires on a hang.
   initial begin
      #4ms;
      $display("%0t ns: run did not complete in time", $time);
      $display("[mailbox_command_retry_engine] ERROR");
      $finish;
   end

endmodule

/* filelist.f */
hw/rtl/mcre_pkg.sv
hw/rtl/mcre_channels.sv
hw/rtl/mcre_core.sv
hw/rtl/mailbox_command_retry_engine.sv
tb/sv/tb_mailbox_command_retry_engine.sv
